>>> hw/rtl/slpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the symlink path canonicaliser.
// No dependencies; imported by slpc_ctrl, symlink_path_canonicalizer, slpc_path_checker and the testbench.
package slpc_pkg;

  localparam int STORE_DEPTH = 256;  // path store entries
  localparam int AW          = $clog2(STORE_DEPTH);

  localparam int FL_W  = 9;  // fill length / capacity width
  localparam int ERR_W = 2;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] FN_START  = 3'd0;
  localparam logic [2:0] FN_BASE   = 3'd1;
  localparam logic [2:0] FN_TARGET = 3'd2;
  localparam logic [2:0] FN_FINISH = 3'd3;
  localparam logic [2:0] FN_READ   = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LONG  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_BACK,
    ST_DONE
  } slpc_state_t;

  typedef struct packed {
    logic [ERR_W-1:0] status;
    logic [FL_W-1:0]  path_length;
    logic [7:0]       read_byte;
  } slpc_result_t;

endpackage

>>> hw/rtl/slpc_store.sv
`timescale 1ns / 1ps
// Path byte store: one write port, one read port, registered read data.
// Stand-alone; used by symlink_path_canonicalizer.
module slpc_store #(
  parameter int STORE_DEPTH = 256,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/slpc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the canonicaliser: dot flushing, slash rules, backtrack walk.
// Depends on slpc_pkg; drives the write and read ports of slpc_store.
module slpc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_func,
  input  logic [7:0]                 in_byte,
  input  logic [7:0]                 in_idx,
  input  logic [slpc_pkg::FL_W-1:0]  cap_lim,
  output logic                       res_valid,
  input  logic                       res_ready,
  output slpc_pkg::slpc_result_t     res,
  output logic                       wr_en,
  output logic [slpc_pkg::AW-1:0]    wr_addr,
  output logic [7:0]                 wr_data,
  output logic                       rd_en,
  output logic [slpc_pkg::AW-1:0]    rd_addr,
  input  logic [7:0]                 rd_data
);
  import slpc_pkg::*;

  localparam int TCW = $clog2(STORE_DEPTH + 2);

  slpc_state_t      state_r, state_nxt;
  logic [FL_W-1:0]  fill_r, fill_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic [TCW-1:0]   tc_r, tc_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic             last_r, last_nxt;   // store[fill-1] is a slash

  logic [2:0]       func_r;
  logic [7:0]       byte_r;
  logic             in_range_r;

  logic [2:0]       op_func;
  logic [7:0]       op_byte;
  logic             run_exec, back_go, put_req, fin_wr, fill_full, accept;
  logic [7:0]       put_data;
  logic [FL_W-1:0]  fill_m1, fill_m2;
  logic [AW+FL_W-1:0] fill_ext, fill_m2_ext;
  logic [AW+7:0]      idx_ext;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE);
  assign fill_full = (fill_r >= cap_lim);
  assign fill_m1   = fill_r - 1'b1;
  assign fill_m2   = fill_r - 2'd2;
  assign fill_ext    = {{AW{1'b0}}, fill_r};
  assign fill_m2_ext = {{AW{1'b0}}, fill_m2};
  assign idx_ext     = {{AW{1'b0}}, in_idx};
  assign op_func   = (state_r == ST_IDLE) ? in_func : func_r;
  assign op_byte   = (state_r == ST_IDLE) ? in_byte : byte_r;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    pend_nxt  = pend_r;
    tc_nxt    = tc_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    put_req   = 1'b0;
    put_data  = CH_DOT;
    fin_wr    = 1'b0;
    run_exec  = 1'b0;
    back_go   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = fill_m2_ext[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = fill_ext[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DONE;
          unique case (in_func)
            FN_START: begin
              fill_nxt = '0;
              pend_nxt = '0;
              tc_nxt   = '0;
              err_nxt  = ERR_NONE;
            end
            FN_BASE, FN_FINISH: begin
              if (pend_r != 2'd0) state_nxt = ST_FLUSH;
              else run_exec = 1'b1;
            end
            FN_TARGET: begin
              if (32'(tc_r) <= STORE_DEPTH) tc_nxt = tc_r + 1'b1;
              if (32'(tc_nxt) > STORE_DEPTH) err_nxt = ERR_LONG;
              if (err_nxt != ERR_NONE) begin
                // ignored until start
              end else if (fill_full) begin
                err_nxt = ERR_LONG;
              end else if (in_byte == CH_DOT) begin
                if (pend_r < 2'd2) begin
                  pend_nxt = pend_r + 1'b1;
                end else begin
                  put_req  = 1'b1;
                  put_data = CH_DOT;
                end
              end else if (in_byte == CH_SLASH) begin
                if (pend_r == 2'd1) begin
                  pend_nxt = '0;
                end else if (pend_r == 2'd2) begin
                  pend_nxt = '0;
                  back_go  = 1'b1;
                end else if (fill_r != '0 && !last_r) begin
                  put_req  = 1'b1;
                  put_data = CH_SLASH;
                end
              end else if (pend_r != 2'd0) begin
                state_nxt = ST_FLUSH;
              end else begin
                run_exec = 1'b1;
              end
            end
            FN_READ: begin
              rd_en   = 1'b1;
              rd_addr = idx_ext[AW-1:0];
            end
            default: ;
          endcase
        end
      end
      ST_FLUSH: begin
        if (pend_r != 2'd0) begin
          put_req  = 1'b1;
          put_data = CH_DOT;
          pend_nxt = pend_r - 1'b1;
        end else begin
          run_exec  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_BACK: begin
        // rd_data is store[fill_r-1]
        if (rd_data == CH_SLASH) begin
          state_nxt = ST_DONE;
        end else begin
          fill_nxt = fill_m1;
          if (fill_m1 == '0) begin
            state_nxt = ST_DONE;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (run_exec) begin
      unique case (op_func)
        FN_BASE: begin
          if (err_nxt == ERR_NONE && fill_full) begin
            err_nxt = ERR_LONG;
          end else if (!(op_byte == CH_SLASH && fill_r != '0 && last_r)) begin
            put_req  = 1'b1;
            put_data = op_byte;
          end
        end
        FN_TARGET: begin
          put_req  = 1'b1;
          put_data = op_byte;
        end
        FN_FINISH: begin
          if (tc_r == '0) err_nxt = ERR_EMPTY;
          else if (err_nxt != ERR_NONE) ;
          else if (fill_full) err_nxt = ERR_LONG;
          else fin_wr = 1'b1;
        end
        default: ;
      endcase
    end

    // dot-dot-slash: drop one byte, then walk back to just after a slash
    if (back_go && fill_r != '0) begin
      fill_nxt = fill_m1;
      last_nxt = 1'b1;
      if (fill_m1 != '0) begin
        rd_en     = 1'b1;
        state_nxt = ST_BACK;
      end
    end

    if (put_req && err_nxt == ERR_NONE) begin
      if (fill_full) begin
        err_nxt = ERR_LONG;
      end else begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + 1'b1;
        last_nxt = (put_data == CH_SLASH);
      end
    end
    if (fin_wr) wr_en = 1'b1;
    wr_data = fin_wr ? CH_NUL : put_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      pend_r  <= '0;
      tc_r    <= '0;
      err_r   <= ERR_NONE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
      tc_r    <= tc_nxt;
      err_r   <= err_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_func;
      byte_r     <= in_byte;
      in_range_r <= (32'(in_idx) < STORE_DEPTH);
    end
  end

  assign res_valid       = (state_r == ST_DONE);
  assign res.status      = err_r;
  assign res.path_length = fill_r;
  assign res.read_byte   = (func_r == FN_READ && in_range_r) ? rd_data : 8'h00;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en)) else $error("store read and write in one cycle");
  a_back_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BACK) |-> (fill_r != '0)) else $error("backtrack at empty path");
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3) else $error("more than two dots held");
  a_tc_sat: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tc_r) <= STORE_DEPTH + 1) else $error("target count past saturation");

endmodule

>>> hw/rtl/symlink_path_canonicalizer.sv
`timescale 1ns / 1ps
// Top level of the symlink path canonicaliser: capacity register, result register.
// Depends on slpc_pkg, slpc_store and slpc_ctrl.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: func, byte_value, read_index
//  out_    | out | out_tvalid/out_tready| out_tdata: status, path_length, read_byte
//  cfg_    | in  | cfg_we               | cfg_wdata: capacity
//
// An item is accepted in ST_IDLE and its result is loaded from ST_DONE. Held dots
// are written out in ST_FLUSH before the byte that follows them, and a dot-dot-slash
// walk in ST_BACK examines one byte per read of the single read port of the store.
// Synchronous active-low reset; capacity resets to 256, store contents are kept.
// A new beat is accepted while the previous result waits in the output register.
module symlink_path_canonicalizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [2:0] func, [10:3] byte_value, [18:11] read_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] status, [10:2] path_length, [18:11] read_byte
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);
  import slpc_pkg::*;

  logic [FL_W-1:0] cap_r, cap_lim;
  logic            out_valid_r;
  slpc_result_t    out_res_r;
  slpc_result_t    res;
  logic            res_valid, res_ready;
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [7:0]      wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 9'd256;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign cap_lim = (32'(cap_r) > STORE_DEPTH) ? FL_W'(STORE_DEPTH) : cap_r;

  slpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tdata[2:0]),
    .in_byte   (in_tdata[10:3]),
    .in_idx    (in_tdata[18:11]),
    .cap_lim   (cap_lim),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  slpc_store #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.read_byte, out_res_r.path_length, out_res_r.status};

endmodule

>>> verif/slpc_path_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the symlink path canonicaliser: mirrors the path builder, queues one
// expected result per input beat and compares every output beat. Depends on slpc_pkg.
module slpc_path_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [23:0]  in_tdata,   // [2:0] func, [10:3] byte_value, [18:11] read_index
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [23:0]  out_tdata,  // [1:0] status, [10:2] path_length, [18:11] read_byte
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata,
  output int           mismatches,
  output int           outstanding,
  output int           results_seen,
  output logic [255:0] written_map
);
  import slpc_pkg::*;

  localparam int DEPTH = 256;

  // mirrored block state
  logic [7:0]   path_mem [DEPTH];
  bit [255:0]   touched;
  int unsigned  fill_len;
  int unsigned  dots_held;
  int unsigned  tgt_count;
  logic [1:0]   err_code;
  logic [8:0]   cap_reg;

  slpc_result_t expected_results[$];

  wire [1:0] got_status = out_tdata[1:0];
  wire [8:0] got_length = out_tdata[10:2];
  wire [7:0] got_byte   = out_tdata[18:11];

  assign written_map = touched;

  function automatic int unsigned eff_cap();
    return (cap_reg > 9'd256) ? DEPTH : int'(cap_reg);
  endfunction

  function automatic bit ends_in_slash();
    return fill_len > 0 && path_mem[fill_len - 1] == CH_SLASH;
  endfunction

  function automatic void append_char(input logic [7:0] c);
    if (err_code != ERR_NONE) return;
    if (fill_len >= eff_cap()) begin
      err_code = ERR_LONG;
      return;
    end
    path_mem[fill_len] = c;
    touched[fill_len] = 1'b1;
    fill_len++;
  endfunction

  function automatic void release_dots();
    while (dots_held > 0) begin
      append_char(CH_DOT);
      dots_held--;
    end
  endfunction

  // dot-dot-slash: drop the last byte, then walk back to just after a slash
  function automatic void step_back();
    if (fill_len > 0) begin
      fill_len--;
      while (fill_len > 0 && path_mem[fill_len - 1] != CH_SLASH) fill_len--;
    end
  endfunction

  function automatic void take_base(input logic [7:0] c);
    release_dots();
    if (err_code != ERR_NONE) return;
    if (fill_len >= eff_cap()) begin
      err_code = ERR_LONG;
      return;
    end
    if (c != CH_SLASH || !ends_in_slash()) append_char(c);
  endfunction

  function automatic void take_target(input logic [7:0] c);
    if (tgt_count <= DEPTH) tgt_count++;
    if (tgt_count > DEPTH) err_code = ERR_LONG;
    if (err_code != ERR_NONE) return;
    if (fill_len >= eff_cap()) begin
      err_code = ERR_LONG;
      return;
    end
    if (c == CH_DOT) begin
      if (dots_held < 2) dots_held++;
      else append_char(CH_DOT);
      return;
    end
    if (c == CH_SLASH) begin
      if (dots_held == 1) begin
        dots_held = 0;
      end else if (dots_held == 2) begin
        dots_held = 0;
        step_back();
      end else if (fill_len > 0 && !ends_in_slash()) begin
        append_char(CH_SLASH);
      end
      return;
    end
    release_dots();
    append_char(c);
  endfunction

  function automatic void close_path();
    release_dots();
    if (tgt_count == 0) begin
      err_code = ERR_EMPTY;
      return;
    end
    if (err_code != ERR_NONE) return;
    if (fill_len >= eff_cap()) begin
      err_code = ERR_LONG;
      return;
    end
    path_mem[fill_len] = CH_NUL;
    touched[fill_len] = 1'b1;
  endfunction

  function automatic slpc_result_t resolve_beat(input logic [2:0] fn, input logic [7:0] c,
                                                input logic [7:0] idx);
    slpc_result_t r;
    r.read_byte = '0;
    case (fn)
      FN_START: begin
        fill_len = 0;
        dots_held = 0;
        tgt_count = 0;
        err_code = ERR_NONE;
      end
      FN_BASE:   take_base(c);
      FN_TARGET: take_target(c);
      FN_FINISH: close_path();
      FN_READ:   r.read_byte = path_mem[idx];
      default: ;
    endcase
    r.status = err_code;
    r.path_length = 9'(fill_len);
    return r;
  endfunction

  always @(posedge clk) begin
    slpc_result_t want;
    if (!rst_n) begin
      fill_len = 0;
      dots_held = 0;
      tgt_count = 0;
      err_code = ERR_NONE;
      cap_reg = 9'd256;
      expected_results.delete();
    end else begin
      // a result always belongs to a beat accepted on an earlier edge
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $error("result beat with nothing expected: %h", out_tdata);
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          if (got_status !== want.status) begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, got_status);
          end
          if (got_length !== want.path_length) begin
            mismatches++;
            $error("path_length: expected %0d, got %0d", want.path_length, got_length);
          end
          if (got_byte !== want.read_byte) begin
            mismatches++;
            $error("read_byte: expected %0d, got %0d", want.read_byte, got_byte);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(resolve_beat(in_tdata[2:0], in_tdata[10:3], in_tdata[18:11]));
      if (cfg_we) cap_reg = cfg_wdata;
    end
    outstanding = expected_results.size();
  end

endmodule

>>> verif/symlink_path_canonicalizer_tb.sv
`timescale 1ns / 1ps
// Top of the canonicaliser testbench: clock, reset, stimulus, output back-pressure and verdict.
// Depends on slpc_pkg, symlink_path_canonicalizer and slpc_path_checker.
module symlink_path_canonicalizer_tb;
  import slpc_pkg::*;

  localparam logic [2:0] FN_NOP5 = 3'd5;
  localparam logic [2:0] FN_NOP6 = 3'd6;
  localparam logic [2:0] FN_NOP7 = 3'd7;

  localparam int PHASE_BEATS     = 200;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 5000;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [23:0]  in_tdata;   // [2:0] func, [10:3] byte_value, [18:11] read_index
  logic         out_tvalid;
  logic         out_tready;
  logic [23:0]  out_tdata;  // [1:0] status, [10:2] path_length, [18:11] read_byte
  logic         cfg_we;
  logic [8:0]   cfg_wdata;

  int           mismatches;
  int           outstanding;
  int           results_seen;
  logic [255:0] stored_map;

  int           beats_sent;
  int           hold_offs;
  int           idle_cycles;
  int           top_read;
  bit           tx_quiet;

  always #2 clk = ~clk;

  symlink_path_canonicalizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  slpc_path_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .written_map  (stored_map)
  );

  task automatic offer_beat(input logic [2:0] fn, input logic [7:0] c, input logic [7:0] idx);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, idx, c, fn};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    beats_sent++;
  endtask

  // reads only land on store entries that have been written at some point
  task automatic offer_read();
    logic [7:0] idx;
    bit found;
    idx = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    found = 1'b0;
    for (int k = 0; k < 256 && !found; k++) begin
      if (stored_map[idx]) found = 1'b1;
      else idx++;
    end
    if (found) begin
      if (int'(idx) > top_read) top_read = int'(idx);
      offer_beat(FN_READ, 8'($urandom), idx);
    end else begin
      offer_beat(FN_NOP5, 8'($urandom), 8'($urandom));
    end
  endtask

  function automatic logic [7:0] path_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return CH_SLASH;
      3, 4, 5: return CH_DOT;
      6, 7:    return 8'h61 + 8'($urandom_range(0, 25));  // lower-case letter
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic set_capacity(input logic [8:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one path build: start, base, target, finish, read-back, with the odd broken piece
  task automatic stream_path();
    int base_n, tgt_n;
    bit dot_slash;
    tx_quiet = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) != 0) offer_beat(FN_START, 8'($urandom), 8'($urandom));
    base_n = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 280) : $urandom_range(0, 6);
    repeat (base_n) offer_beat(FN_BASE, path_char(), 8'($urandom));
    tgt_n = ($urandom_range(0, 19) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 12);
    // long "./" runs keep the path short so only the target count overflows
    dot_slash = (tgt_n > 200) && ($urandom_range(0, 1) == 0);
    for (int k = 0; k < tgt_n; k++) begin
      if (dot_slash) offer_beat(FN_TARGET, k[0] ? CH_SLASH : CH_DOT, 8'($urandom));
      else offer_beat(FN_TARGET, path_char(), 8'($urandom));
      if ($urandom_range(0, 39) == 0) offer_beat(FN_BASE, path_char(), 8'($urandom));
    end
    if ($urandom_range(0, 7) != 0) offer_beat(FN_FINISH, 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 5) == 0) offer_beat(FN_FINISH, 8'($urandom), 8'($urandom));
    repeat ($urandom_range(0, 3)) offer_read();
    if ($urandom_range(0, 4) == 0) begin
      logic [2:0] fn;
      fn = 3'($urandom_range(0, 7));
      if (fn == FN_READ) offer_read();
      else offer_beat(fn, 8'($urandom), 8'($urandom));
    end
  endtask

  // output side: random stalls, calm stretches and two long hold-offs
  initial begin : receiver
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == 500 || taken == 1200) begin
        hold_offs++;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      stall = calm ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("symlink_path_canonicalizer_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [8:0] caps [8];
    caps = '{9'd1, 9'd2, 9'd37, 9'd511, 9'd300, 9'd9, 9'd256, 9'd128};
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    beats_sent = 0;
    top_read   = 0;
    tx_quiet   = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    set_capacity(9'd256);
    // directed: slash collapse, dot handling in target, held dots before a base byte
    offer_beat(FN_START, 8'hFF, 8'hFF);
    offer_beat(FN_BASE, CH_SLASH, 8'h00);
    offer_beat(FN_BASE, CH_SLASH, 8'h00);
    offer_beat(FN_BASE, 8'h75, 8'h00);
    offer_beat(FN_TARGET, CH_DOT, 8'h00);    // dot-slash dropped
    offer_beat(FN_TARGET, CH_SLASH, 8'h00);
    offer_beat(FN_TARGET, 8'h64, 8'h00);
    offer_beat(FN_TARGET, CH_SLASH, 8'h00);
    offer_beat(FN_TARGET, CH_SLASH, 8'h00);
    offer_beat(FN_TARGET, CH_DOT, 8'h00);    // dot-dot-slash backs up
    offer_beat(FN_TARGET, CH_DOT, 8'h00);
    offer_beat(FN_TARGET, CH_SLASH, 8'h00);
    offer_beat(FN_TARGET, CH_DOT, 8'h00);    // third dot emits one, two stay held
    offer_beat(FN_TARGET, CH_DOT, 8'h00);
    offer_beat(FN_TARGET, CH_DOT, 8'h00);
    offer_beat(FN_BASE, 8'h7A, 8'h00);
    offer_beat(FN_FINISH, 8'h00, 8'h00);
    offer_beat(FN_READ, 8'h00, 8'h00);
    offer_beat(FN_NOP5, 8'h00, 8'h00);
    offer_beat(FN_NOP6, 8'hFF, 8'hFF);
    offer_beat(FN_NOP7, 8'h00, 8'h00);
    offer_beat(FN_START, 8'h00, 8'h00);
    offer_beat(FN_FINISH, 8'h00, 8'h00);     // empty target
    offer_beat(FN_TARGET, CH_SLASH, 8'h00);  // leading slash not placed
    offer_beat(FN_FINISH, 8'h00, 8'h00);
    offer_beat(FN_FINISH, 8'h00, 8'h00);

    foreach (caps[p]) begin
      int phase_end;
      set_capacity(caps[p]);
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) stream_path();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (10) @(negedge clk);

    $display("summary: %0d input beats, %0d results compared, 9 capacity settings from 1 to 511",
             beats_sent, results_seen);
    $display("summary: %0d long output hold-offs, highest store index read %0d",
             hold_offs, top_read);
    if (mismatches == 0) begin
      $display("symlink_path_canonicalizer_tb: done, clean");
    end else begin
      $display("symlink_path_canonicalizer_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/slpc_pkg.sv
hw/rtl/slpc_store.sv
hw/rtl/slpc_ctrl.sv
hw/rtl/symlink_path_canonicalizer.sv
verif/slpc_path_checker.sv
verif/symlink_path_canonicalizer_tb.sv
